// ----- hw/rtl/bss_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// bss_pkg
// Shared types and constants of the bracket-aware separator scanner.
// ---------------------------------------------------------------------------
package bss_pkg;

	localparam int STACK_DEPTH = 16;
	localparam int NUM_PAIRS   = 4;
	localparam int PAIR_SLOTS  = 4;

	localparam int SYM_W   = 8;
	localparam int PAIR_W  = 16;
	localparam int EN_W    = PAIR_SLOTS;
	localparam int DEPTH_W = 5;
	localparam int LVL_W   = $clog2(STACK_DEPTH + 1);
	localparam int PTR_W   = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SEPARATOR   = 3'd0,
		REG_PAIR_ZERO   = 3'd1,
		REG_PAIR_ONE    = 3'd2,
		REG_PAIR_TWO    = 3'd3,
		REG_PAIR_THREE  = 3'd4,
		REG_PAIR_ENABLE = 3'd5
	} cfg_reg_t;

	localparam logic [SYM_W-1:0] SEPARATOR_RESET = 8'h2C;
	localparam logic [EN_W-1:0]  ENABLE_RESET    = 4'hF;
	localparam logic [PAIR_W-1:0] PAIR_RESET [PAIR_SLOTS] = '{
		16'h2928, // ( )
		16'h5D5B, // [ ]
		16'h7D7B, // { }
		16'h2222  // " "
	};

endpackage
`default_nettype wire

// ----- hw/rtl/bss_ifs.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// bss channel interfaces
// Valid/ready channels for symbols, results and register writes.
// ---------------------------------------------------------------------------
interface bss_sym_if;
	logic                        valid;
	logic                        ready;
	logic [bss_pkg::SYM_W-1:0]   symbol;
	logic                        restart;

	modport source (output valid, output symbol, output restart, input ready);
	modport sink   (input valid, input symbol, input restart, output ready);
endinterface

interface bss_res_if;
	logic                        valid;
	logic                        ready;
	logic                        split_here;
	logic                        outer_closed;
	logic [bss_pkg::DEPTH_W-1:0] nest_depth;
	logic                        overflowed;

	modport source (output valid, output split_here, output outer_closed,
		output nest_depth, output overflowed, input ready);
	modport sink   (input valid, input split_here, input outer_closed,
		input nest_depth, input overflowed, output ready);
endinterface

interface bss_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [bss_pkg::CFG_IDX_W-1:0]  index;
	logic [bss_pkg::CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/bracket_aware_separator_scanner_top.sv -----
// Path: an accepted symbol beat passes the input register, then the result register.
// Throughput: one symbol per cycle unless scan_out stalls; the stack update closes
// within the cycle that moves a beat from the input register to the result register.
// Reset: control state, level and overflow clear at once; registers return to
// their defaults; stack entries are left as they are.
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// bracket_aware_separator_scanner_top
// Tracks open brackets on a close-byte stack and flags top-level separators.
// ---------------------------------------------------------------------------
module bracket_aware_separator_scanner_top (
	input  wire         clk,
	input  wire         arst_n,
	bss_sym_if.sink     scan_in,
	bss_res_if.source   scan_out,
	bss_cfg_if.sink     cfg
);

	// configuration registers
	logic [bss_pkg::SYM_W-1:0]  separator_q;
	logic [bss_pkg::PAIR_W-1:0] pair_q [bss_pkg::PAIR_SLOTS];
	logic [bss_pkg::EN_W-1:0]   enable_q;

	// state
	logic [bss_pkg::SYM_W-1:0]  stack_q [bss_pkg::STACK_DEPTH];
	logic [bss_pkg::LVL_W-1:0]  level_q;
	logic                       ovf_q;

	// input stage
	logic                       vld_s1;
	logic [bss_pkg::SYM_W-1:0]  sym_s1;
	logic                       restart_s1;

	// result stage
	logic                       vld_s2;
	logic                       split_s2;
	logic                       closed_s2;
	logic [bss_pkg::DEPTH_W-1:0] depth_s2;
	logic                       ovf_s2;

	logic                       advance;
	logic [bss_pkg::LVL_W-1:0]  lvl_eff;
	logic [bss_pkg::LVL_W-1:0]  lvl_m1;
	logic [bss_pkg::LVL_W-1:0]  lvl_nxt;
	logic                       ovf_eff;
	logic                       ovf_nxt;
	logic                       pop_hit;
	logic                       open_hit;
	logic [bss_pkg::SYM_W-1:0]  closer;
	logic                       full;
	logic                       do_push;
	logic                       split_nxt;
	logic                       closed_nxt;

	assign advance       = vld_s1 && (!vld_s2 || scan_out.ready);
	assign scan_in.ready = !vld_s1 || advance;
	assign cfg.ready     = 1'b1;

	assign lvl_eff = restart_s1 ? '0 : level_q;
	assign ovf_eff = restart_s1 ? 1'b0 : ovf_q;
	assign lvl_m1  = lvl_eff - bss_pkg::LVL_W'(1);
	assign full    = (lvl_eff == bss_pkg::LVL_W'(bss_pkg::STACK_DEPTH));

	assign pop_hit = (lvl_eff != '0) &&
		(stack_q[lvl_m1[bss_pkg::PTR_W-1:0]] == sym_s1);

	// lowest enabled pair wins
	always_comb begin
		open_hit = 1'b0;
		closer   = '0;
		for (int k = bss_pkg::NUM_PAIRS - 1; k >= 0; k--) begin
			if (enable_q[k] && (pair_q[k][bss_pkg::SYM_W-1:0] == sym_s1)) begin
				open_hit = 1'b1;
				closer   = pair_q[k][bss_pkg::PAIR_W-1:bss_pkg::SYM_W];
			end
		end
	end

	assign do_push = !pop_hit && open_hit && !full;

	always_comb begin
		lvl_nxt    = lvl_eff;
		ovf_nxt    = ovf_eff;
		split_nxt  = 1'b0;
		closed_nxt = 1'b0;
		if (pop_hit) begin
			lvl_nxt    = lvl_m1;
			closed_nxt = (lvl_m1 == '0);
		end else if (open_hit) begin
			if (full) begin
				ovf_nxt = 1'b1;
			end else begin
				lvl_nxt = lvl_eff + bss_pkg::LVL_W'(1);
			end
		end else if ((lvl_eff == '0) && (sym_s1 == separator_q)) begin
			split_nxt = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			separator_q <= bss_pkg::SEPARATOR_RESET;
			enable_q    <= bss_pkg::ENABLE_RESET;
			for (int k = 0; k < bss_pkg::PAIR_SLOTS; k++) begin
				pair_q[k] <= bss_pkg::PAIR_RESET[k];
			end
		end else if (cfg.valid) begin
			unique case (bss_pkg::cfg_reg_t'(cfg.index))
				bss_pkg::REG_SEPARATOR: begin
					separator_q <= cfg.data[bss_pkg::SYM_W-1:0];
				end
				bss_pkg::REG_PAIR_ZERO: begin
					pair_q[0] <= cfg.data;
				end
				bss_pkg::REG_PAIR_ONE: begin
					pair_q[1] <= cfg.data;
				end
				bss_pkg::REG_PAIR_TWO: begin
					pair_q[2] <= cfg.data;
				end
				bss_pkg::REG_PAIR_THREE: begin
					pair_q[3] <= cfg.data;
				end
				bss_pkg::REG_PAIR_ENABLE: begin
					enable_q <= cfg.data[bss_pkg::EN_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (advance && do_push) begin
			stack_q[lvl_eff[bss_pkg::PTR_W-1:0]] <= closer;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q <= '0;
			ovf_q   <= 1'b0;
		end else if (advance) begin
			level_q <= lvl_nxt;
			ovf_q   <= ovf_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (scan_in.ready) begin
			vld_s1 <= scan_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (scan_in.valid && scan_in.ready) begin
			sym_s1     <= scan_in.symbol;
			restart_s1 <= scan_in.restart;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (advance) begin
			vld_s2 <= 1'b1;
		end else if (scan_out.ready) begin
			vld_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			split_s2  <= split_nxt;
			closed_s2 <= closed_nxt;
			depth_s2  <= bss_pkg::DEPTH_W'(lvl_nxt);
			ovf_s2    <= ovf_nxt;
		end
	end

	assign scan_out.valid        = vld_s2;
	assign scan_out.split_here   = split_s2;
	assign scan_out.outer_closed = closed_s2;
	assign scan_out.nest_depth   = depth_s2;
	assign scan_out.overflowed   = ovf_s2;

`ifndef SYNTHESIS
	a_level_bound: assert property (@(posedge clk) disable iff (!arst_n)
		level_q <= bss_pkg::LVL_W'(bss_pkg::STACK_DEPTH))
		else $error("stack level beyond depth");

	a_ovf_on_full: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(ovf_q) |-> level_q == bss_pkg::LVL_W'(bss_pkg::STACK_DEPTH))
		else $error("overflow set below full stack");

	a_close_empty: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s2 && closed_s2 |-> depth_s2 == '0 && !split_s2)
		else $error("outer close with stack still open");

	a_split_empty: assert property (@(posedge clk) disable iff (!arst_n)
		advance && split_nxt |=> level_q == '0)
		else $error("split inside brackets");
`endif

endmodule
`default_nettype wire

// ----- tb/sv/bracket_aware_separator_scanner_top_tb.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bracket_aware_separator_scanner_top_tb
// Drives byte beats through the scanner under random source gaps and sink
// stalls, predicts split, close, depth and overflow flags from a private copy
// of the close-byte stack, and checks every result beat in order. The run
// walks through default, extreme, disabled and random bracket settings.
// ---------------------------------------------------------------------------
module bracket_aware_separator_scanner_top_tb;

	localparam int QUIET_LIMIT = 400;
	localparam int END_PAUSE   = 8;
	localparam int BYTE_TARGET = 400;

	localparam logic [bss_pkg::CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
	localparam logic [bss_pkg::CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

	localparam logic [bss_pkg::SYM_W-1:0] CH_LPAREN = "(";
	localparam logic [bss_pkg::SYM_W-1:0] CH_RPAREN = ")";
	localparam logic [bss_pkg::SYM_W-1:0] CH_LSQ    = "[";
	localparam logic [bss_pkg::SYM_W-1:0] CH_RSQ    = "]";
	localparam logic [bss_pkg::SYM_W-1:0] CH_LCURLY = "{";
	localparam logic [bss_pkg::SYM_W-1:0] CH_RCURLY = "}";
	localparam logic [bss_pkg::SYM_W-1:0] CH_QUOTE  = "\"";
	localparam logic [bss_pkg::SYM_W-1:0] CH_COMMA  = ",";
	localparam logic [bss_pkg::SYM_W-1:0] CH_LOW    = 8'h00;
	localparam logic [bss_pkg::SYM_W-1:0] CH_HIGH   = 8'hFF;

	typedef struct packed {
		logic                        split_here;
		logic                        outer_closed;
		logic [bss_pkg::DEPTH_W-1:0] nest_depth;
		logic                        overflowed;
	} scan_flags_t;

	class depth_scoreboard;
		logic [bss_pkg::SYM_W-1:0]  separator;
		logic [bss_pkg::PAIR_W-1:0] pairs [bss_pkg::PAIR_SLOTS];
		logic [bss_pkg::EN_W-1:0]   enables;
		logic [bss_pkg::SYM_W-1:0]  closers [bss_pkg::STACK_DEPTH];
		int unsigned                level;
		bit                         overflow;
		scan_flags_t                expected_flags [$];
		int unsigned                failures, checked, splits, closes, ovf_beats, deepest;

		function new();
			separator = bss_pkg::SEPARATOR_RESET;
			enables   = bss_pkg::ENABLE_RESET;
			for (int k = 0; k < bss_pkg::PAIR_SLOTS; k++)
				pairs[k] = bss_pkg::PAIR_RESET[k];
			level    = 0;
			overflow = 1'b0;
		endfunction

		function void apply_write(logic [bss_pkg::CFG_IDX_W-1:0] idx,
				logic [bss_pkg::CFG_DATA_W-1:0] data);
			case (idx)
				bss_pkg::REG_SEPARATOR:   separator = data[bss_pkg::SYM_W-1:0];
				bss_pkg::REG_PAIR_ZERO:   pairs[0]  = data[bss_pkg::PAIR_W-1:0];
				bss_pkg::REG_PAIR_ONE:    pairs[1]  = data[bss_pkg::PAIR_W-1:0];
				bss_pkg::REG_PAIR_TWO:    pairs[2]  = data[bss_pkg::PAIR_W-1:0];
				bss_pkg::REG_PAIR_THREE:  pairs[3]  = data[bss_pkg::PAIR_W-1:0];
				bss_pkg::REG_PAIR_ENABLE: enables   = data[bss_pkg::EN_W-1:0];
				default: ;
			endcase
		endfunction

		function void predict_byte(logic [bss_pkg::SYM_W-1:0] sym, logic rst);
			scan_flags_t               f;
			logic [bss_pkg::SYM_W-1:0] closer;
			bit                        opened;
			f      = '0;
			opened = 1'b0;
			closer = '0;
			if (rst) begin
				level    = 0;
				overflow = 1'b0;
			end
			if (level > 0 && closers[level-1] == sym) begin
				level--;
				f.outer_closed = (level == 0);
			end else begin
				for (int k = 0; k < bss_pkg::NUM_PAIRS; k++) begin
					if (!opened && enables[k] && pairs[k][7:0] == sym) begin
						opened = 1'b1;
						closer = pairs[k][15:8];
					end
				end
				if (opened) begin
					if (level < bss_pkg::STACK_DEPTH) begin
						closers[level] = closer;
						level++;
					end else begin
						overflow = 1'b1;
					end
				end else if (level == 0 && sym == separator) begin
					f.split_here = 1'b1;
				end
			end
			f.nest_depth = bss_pkg::DEPTH_W'(level);
			f.overflowed = overflow;
			expected_flags = {expected_flags, f};
		endfunction

		function void check_flags(scan_flags_t got);
			scan_flags_t want;
			if (expected_flags.size() == 0) begin
				$error("result beat with nothing expected");
				failures++;
				return;
			end
			want = expected_flags.pop_front();
			checked++;
			if (got.split_here !== want.split_here) begin
				$error("split_here: expected %0d, got %0d", want.split_here, got.split_here);
				failures++;
			end
			if (got.outer_closed !== want.outer_closed) begin
				$error("outer_closed: expected %0d, got %0d", want.outer_closed,
					got.outer_closed);
				failures++;
			end
			if (got.nest_depth !== want.nest_depth) begin
				$error("nest_depth: expected %0d, got %0d", want.nest_depth, got.nest_depth);
				failures++;
			end
			if (got.overflowed !== want.overflowed) begin
				$error("overflowed: expected %0d, got %0d", want.overflowed, got.overflowed);
				failures++;
			end
			splits    += 32'(want.split_here);
			closes    += 32'(want.outer_closed);
			ovf_beats += 32'(want.overflowed);
			if (32'(want.nest_depth) > deepest)
				deepest = 32'(want.nest_depth);
		endfunction

		function int pending();
			return expected_flags.size();
		endfunction
	endclass

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	bss_sym_if scan_in_if ();
	bss_res_if scan_out_if ();
	bss_cfg_if cfg_if ();

	bracket_aware_separator_scanner_top dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.scan_in  (scan_in_if),
		.scan_out (scan_out_if),
		.cfg      (cfg_if)
	);

	depth_scoreboard sb = new();

	int unsigned bytes_sent;
	int unsigned cfg_writes;
	int unsigned settings_used;
	int unsigned quiet_cycles;
	bit          src_gaps;
	logic [bss_pkg::CFG_IDX_W-1:0]  staged_idx [$];
	logic [bss_pkg::CFG_DATA_W-1:0] staged_val [$];

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	initial begin
		scan_in_if.valid   <= 1'b0;
		scan_in_if.symbol  <= '0;
		scan_in_if.restart <= 1'b0;
		scan_out_if.ready  <= 1'b0;
		cfg_if.valid       <= 1'b0;
		cfg_if.index       <= '0;
		cfg_if.data        <= '0;
	end

	always @(posedge clk) begin
		if (!arst_n || (scan_in_if.valid && scan_in_if.ready) ||
				(scan_out_if.valid && scan_out_if.ready) || (cfg_if.valid && cfg_if.ready)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("Some tests failed");
				$finish;
			end
		end
	end

	// result sink with random back-pressure
	initial begin
		int          stall;
		bit          stall_on;
		scan_flags_t got;
		stall_on = 1;
		wait (arst_n);
		forever begin
			stall = stall_on ? $urandom_range(0, 15) : 0;
			if (stall > 0) begin
				scan_out_if.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			scan_out_if.ready <= 1'b1;
			do @(posedge clk); while (!scan_out_if.valid);
			got.split_here   = scan_out_if.split_here;
			got.outer_closed = scan_out_if.outer_closed;
			got.nest_depth   = scan_out_if.nest_depth;
			got.overflowed   = scan_out_if.overflowed;
			sb.check_flags(got);
			if ($urandom_range(0, 39) == 0)
				stall_on = !stall_on;
		end
	end

	task automatic send_byte(input logic [bss_pkg::SYM_W-1:0] sym, input logic rst);
		int gap;
		gap = src_gaps ? $urandom_range(0, 15) : 0;
		if (gap > 0) begin
			scan_in_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		scan_in_if.valid   <= 1'b1;
		scan_in_if.symbol  <= sym;
		scan_in_if.restart <= rst;
		do @(posedge clk); while (!scan_in_if.ready);
		sb.predict_byte(sym, rst);
		bytes_sent++;
	endtask

	task automatic drain();
		scan_in_if.valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	function automatic void stage_reg(input logic [bss_pkg::CFG_IDX_W-1:0] idx,
			input logic [bss_pkg::CFG_DATA_W-1:0] val);
		staged_idx = {staged_idx, idx};
		staged_val = {staged_val, val};
	endfunction

	task automatic flush_regs();
		while (staged_idx.size() != 0) begin
			cfg_if.valid <= 1'b1;
			cfg_if.index <= staged_idx[0];
			cfg_if.data  <= staged_val[0];
			do @(posedge clk); while (!cfg_if.ready);
			sb.apply_write(staged_idx.pop_front(), staged_val.pop_front());
			cfg_writes++;
		end
		cfg_if.valid <= 1'b0;
		settings_used++;
	endtask

	function automatic logic draw_restart();
		return ($urandom_range(0, 49) == 0);
	endfunction

	function automatic logic [bss_pkg::SYM_W-1:0] pick_byte();
		int k;
		k = $urandom_range(0, bss_pkg::PAIR_SLOTS - 1);
		case ($urandom_range(0, 5))
			0:       return sb.separator;
			1:       return sb.pairs[k][7:0];
			2:       return sb.pairs[k][15:8];
			default: return bss_pkg::SYM_W'($urandom);
		endcase
	endfunction

	function automatic logic [bss_pkg::SYM_W-1:0] pool_byte();
		if ($urandom_range(0, 3) == 0)
			return bss_pkg::SYM_W'($urandom);
		return bss_pkg::SYM_W'($urandom_range(8'h20, 8'h2F));
	endfunction

	task automatic send_filler();
		repeat ($urandom_range(0, 2))
			send_byte(($urandom_range(0, 2) == 0) ? sb.separator : pick_byte(), 1'b0);
	endtask

	// well-formed nesting with random content between the brackets
	task automatic send_nest(input int depth);
		logic [bss_pkg::SYM_W-1:0] closing [$];
		int                        k;
		for (int i = 0; i < depth && sb.enables != '0; i++) begin
			do k = $urandom_range(0, bss_pkg::PAIR_SLOTS - 1); while (!sb.enables[k]);
			send_filler();
			send_byte(sb.pairs[k][7:0], 1'b0);
			closing = {closing, sb.pairs[k][15:8]};
		end
		while (closing.size() != 0) begin
			send_filler();
			send_byte(closing.pop_back(), 1'b0);
		end
		send_filler();
	endtask

	task automatic send_broken();
		int k;
		repeat ($urandom_range(1, 4)) begin
			k = $urandom_range(0, bss_pkg::PAIR_SLOTS - 1);
			send_byte(sb.pairs[k][7:0], 1'b0);
		end
		repeat ($urandom_range(0, 4)) begin
			k = $urandom_range(0, bss_pkg::PAIR_SLOTS - 1);
			send_byte(sb.pairs[k][15:8], draw_restart());
		end
	endtask

	task automatic random_stream(input int quota, input bit start_deep);
		int unsigned stop_at;
		int          pick;
		stop_at = bytes_sent + quota;
		if (start_deep)
			send_nest($urandom_range(17, 20));
		while (bytes_sent < stop_at) begin
			if ($urandom_range(0, 7) == 0)
				src_gaps = !src_gaps;
			pick = $urandom_range(0, 9);
			if (pick < 6) begin
				send_nest(($urandom_range(0, 7) == 0) ? $urandom_range(12, 20) :
					$urandom_range(0, 4));
			end else if (pick < 8) begin
				repeat ($urandom_range(1, 8))
					send_byte(pick_byte(), draw_restart());
			end else begin
				send_broken();
			end
		end
		drain();
	endtask

	task automatic random_settings();
		logic [bss_pkg::SYM_W-1:0] open_b, close_b;
		for (int k = 0; k < bss_pkg::PAIR_SLOTS; k++) begin
			open_b  = pool_byte();
			close_b = ($urandom_range(0, 3) == 0) ? open_b : pool_byte();
			stage_reg(bss_pkg::CFG_IDX_W'(int'(bss_pkg::REG_PAIR_ZERO) + k),
				{close_b, open_b});
		end
		stage_reg(bss_pkg::REG_SEPARATOR, {bss_pkg::SYM_W'($urandom), pool_byte()});
		stage_reg(bss_pkg::REG_PAIR_ENABLE, bss_pkg::CFG_DATA_W'($urandom));
		flush_regs();
	endtask

	initial begin
		src_gaps = 1;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// defaults: nesting, self-closing quote, mismatched close, restart
		send_byte(CH_COMMA, 1'b1);
		send_byte(CH_LPAREN, 1'b0);
		send_byte(CH_COMMA, 1'b0);
		send_byte(CH_LSQ, 1'b0);
		send_byte(CH_QUOTE, 1'b0);
		send_byte(CH_LPAREN, 1'b0);
		send_byte(CH_RPAREN, 1'b0);
		send_byte(CH_QUOTE, 1'b0);
		send_byte(CH_RSQ, 1'b0);
		send_byte(CH_RCURLY, 1'b0);
		send_byte(CH_RPAREN, 1'b0);
		send_byte(CH_COMMA, 1'b0);
		send_byte(CH_LOW, 1'b0);
		send_byte(CH_HIGH, 1'b0);
		send_byte(CH_LCURLY, 1'b0);
		send_byte(CH_LCURLY, 1'b1);
		send_byte(CH_RCURLY, 1'b0);
		send_byte(CH_QUOTE, 1'b0);
		send_byte(CH_QUOTE, 1'b0);
		drain();
		settings_used++;
		random_stream(70, 1'b1);

		// extremes: shared open bytes, separator equal to an open byte
		stage_reg(bss_pkg::REG_SEPARATOR, 16'h00FF);
		stage_reg(bss_pkg::REG_PAIR_ZERO, 16'hFF00);
		stage_reg(bss_pkg::REG_PAIR_ONE, 16'h00FF);
		stage_reg(bss_pkg::REG_PAIR_TWO, 16'h4100);
		stage_reg(bss_pkg::REG_PAIR_THREE, 16'hFFFF);
		stage_reg(bss_pkg::REG_PAIR_ENABLE, 16'h000F);
		flush_regs();
		send_byte(CH_LOW, 1'b0);
		send_byte(CH_HIGH, 1'b0);
		send_byte(CH_HIGH, 1'b0);
		send_byte(CH_LOW, 1'b0);
		send_byte(CH_HIGH, 1'b0);
		drain();
		random_stream(50, 1'b1);

		// all pairs off; masked data and unused indexes
		stage_reg(bss_pkg::REG_SEPARATOR, 16'hA500);
		stage_reg(bss_pkg::REG_PAIR_ENABLE, 16'hFFF0);
		stage_reg(REG_SPARE_LO, 16'hFFFF);
		stage_reg(REG_SPARE_HI, 16'h0000);
		flush_regs();
		send_byte(CH_LOW, 1'b0);
		send_byte(CH_LPAREN, 1'b0);
		drain();
		random_stream(30, 1'b0);

		while (bytes_sent < BYTE_TARGET) begin
			random_settings();
			random_stream(60, 1'($urandom_range(0, 1)));
		end

		drain();
		repeat (END_PAUSE) @(posedge clk);
		$display("Scanned %0d bytes under %0d register settings (%0d writes).",
			bytes_sent, settings_used, cfg_writes);
		$display("Checked %0d results: %0d splits, %0d outer closes, %0d overflowed,",
			sb.checked, sb.splits, sb.closes, sb.ovf_beats);
		$display("deepest nesting seen %0d.", sb.deepest);
		if (sb.failures == 0 && sb.pending() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end
endmodule

// ----- bracket_aware_separator_scanner_top.f -----
hw/rtl/bss_pkg.sv
hw/rtl/bss_ifs.sv
hw/rtl/bracket_aware_separator_scanner_top.sv
tb/sv/bracket_aware_separator_scanner_top_tb.sv
